// ===== design/sqp_pkg.sv =====
package sqp_pkg;

  localparam int CW = 5;

  localparam logic [1:0] MODE_ENQ     = 2'd0;
  localparam logic [1:0] MODE_DEQ     = 2'd1;
  localparam logic [1:0] MODE_PROMOTE = 2'd2;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_EMPTY   = 2'd3;

  localparam logic [7:0] CODE_LOW  = 8'h41;
  localparam logic [7:0] CODE_HIGH = 8'h5A;

  localparam logic [CW-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEQ,
    ST_WALK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic          we;
    logic          wbank;
    logic [CW-1:0] wptr;
    logic [7:0]    wdata;
    logic          rbank;
    logic [CW-1:0] rptr;
  } store_ctl_t;

endpackage

// ===== design/service_queue_with_promotion_core.sv =====
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  s_tdata: mode[1:0], code[9:2]
// m_axis    out  m_tvalid/m_tready  m_tdata: status[1:0], served_code[9:2], fill_after[14:10]
// cfg       in   cfg_we             cfg_wdata: capacity[4:0]
//
// Dequeue uses a registered store read; promote makes two passes of the
// shared read-compare loop over the store.
// Promote writes into the other bank of the store, then swaps banks.
// Reset (rst, synchronous) empties the queue and sets capacity to 16.
// A result waits in the output register; the block stalls in its response
// step only while that register is still held by m_tready low.
module service_queue_with_promotion_core #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // mode[1:0], code[9:2], zero[15:10]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // status[1:0], served_code[9:2], fill_after[14:10], zero[15]
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);

  localparam int CW    = sqp_pkg::CW;
  localparam int SLOTS = (DEPTH < 31) ? DEPTH : 31;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [CW-1:0] CAP_MAX = CW'(SLOTS);

  sqp_pkg::state_t     state, state_next;
  sqp_pkg::store_ctl_t ctl;

  logic [CW-1:0] capacity;
  logic [CW-1:0] cap_eff;
  logic [CW-1:0] wp;
  logic [CW-1:0] fill;
  logic          bank;
  logic [CW-1:0] j;
  logic [CW-1:0] issued;
  logic [CW-1:0] n;
  logic          rd_pend;
  logic          pass;
  logic [7:0]    code_r;
  logic [1:0]    res_status;
  logic [7:0]    res_served;
  logic [7:0]    rdata;

  logic [1:0]    in_mode;
  logic [7:0]    in_code;
  logic          accept;
  logic          code_ok;
  logic [CW:0]   oldest_wide;
  logic [CW-1:0] oldest;
  logic [CW-1:0] wp_inc;
  logic [CW-1:0] j_inc;
  logic          issue;
  logic          take;
  logic          walk_end;
  logic          out_free;
  logic          out_load;
  logic          enq_ok;
  logic          deq_ok;

  assign in_mode = s_tdata[1:0];
  assign in_code = s_tdata[9:2];
  assign accept  = s_tvalid && s_tready;
  assign code_ok = in_code inside {[sqp_pkg::CODE_LOW:sqp_pkg::CODE_HIGH]};

  assign cap_eff = (capacity == '0)     ? CW'(1) :
                   (capacity > CAP_MAX) ? CAP_MAX : capacity;

  assign oldest_wide = (wp >= fill) ? {1'b0, wp} - {1'b0, fill}
                                    : {1'b0, wp} + {1'b0, cap_eff} - {1'b0, fill};
  assign oldest = oldest_wide[CW-1:0];

  assign wp_inc = (wp + CW'(1) == cap_eff) ? '0 : wp + CW'(1);
  assign j_inc  = (j + CW'(1) == cap_eff) ? '0 : j + CW'(1);

  assign issue    = (state == sqp_pkg::ST_WALK) && (issued != fill);
  assign take     = rd_pend && ((rdata == code_r) == !pass);
  assign walk_end = !issue && !rd_pend;
  assign out_free = !m_tvalid || m_tready;
  assign enq_ok   = code_ok && (fill < cap_eff);
  assign deq_ok   = fill != '0;

  sqp_store #(.AW(AW)) u_store (
    .clk   (clk),
    .ctl   (ctl),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      sqp_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_mode == sqp_pkg::MODE_DEQ && deq_ok) begin
            state_next = sqp_pkg::ST_DEQ;
          end else if (in_mode == sqp_pkg::MODE_PROMOTE && code_ok) begin
            state_next = sqp_pkg::ST_WALK;
          end else begin
            state_next = sqp_pkg::ST_RESP;
          end
        end
      end
      sqp_pkg::ST_DEQ:  state_next = sqp_pkg::ST_RESP;
      sqp_pkg::ST_WALK: begin
        if (walk_end && pass) begin
          state_next = sqp_pkg::ST_RESP;
        end
      end
      sqp_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = sqp_pkg::ST_IDLE;
        end
      end
      default: state_next = sqp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == sqp_pkg::ST_IDLE);
    out_load  = (state == sqp_pkg::ST_RESP) && out_free;
    ctl.we    = 1'b0;
    ctl.wbank = bank;
    ctl.wptr  = wp;
    ctl.wdata = in_code;
    ctl.rbank = bank;
    ctl.rptr  = oldest;
    case (state)
      sqp_pkg::ST_IDLE: begin
        ctl.we = accept && (in_mode == sqp_pkg::MODE_ENQ) && enq_ok;
      end
      sqp_pkg::ST_WALK: begin
        ctl.rptr  = j;
        ctl.we    = take;
        ctl.wbank = !bank;
        ctl.wptr  = n;
        ctl.wdata = rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sqp_pkg::ST_IDLE;
      capacity <= sqp_pkg::CAP_RESET;
      wp       <= '0;
      fill     <= '0;
      bank     <= 1'b0;
      rd_pend  <= 1'b0;
      pass     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
        wp       <= '0;
        fill     <= '0;
      end
      case (state)
        sqp_pkg::ST_IDLE: begin
          if (accept) begin
            code_r     <= in_code;
            res_served <= '0;
            res_status <= sqp_pkg::STATUS_INVALID;
            j          <= oldest;
            issued     <= '0;
            n          <= '0;
            pass       <= 1'b0;
            rd_pend    <= 1'b0;
            case (in_mode)
              sqp_pkg::MODE_ENQ: begin
                if (!code_ok) begin
                  res_status <= sqp_pkg::STATUS_INVALID;
                end else if (!enq_ok) begin
                  res_status <= sqp_pkg::STATUS_FULL;
                end else begin
                  res_status <= sqp_pkg::STATUS_DONE;
                  wp         <= wp_inc;
                  fill       <= fill + CW'(1);
                end
              end
              sqp_pkg::MODE_DEQ: begin
                if (deq_ok) begin
                  res_status <= sqp_pkg::STATUS_DONE;
                  fill       <= fill - CW'(1);
                end else begin
                  res_status <= sqp_pkg::STATUS_EMPTY;
                end
              end
              sqp_pkg::MODE_PROMOTE: begin
                if (code_ok) begin
                  res_status <= sqp_pkg::STATUS_DONE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        sqp_pkg::ST_DEQ: begin
          res_served <= rdata;
        end
        sqp_pkg::ST_WALK: begin
          rd_pend <= issue;
          if (issue) begin
            j      <= j_inc;
            issued <= issued + CW'(1);
          end
          if (take) begin
            n <= n + CW'(1);
          end
          if (walk_end) begin
            if (!pass) begin
              pass   <= 1'b1;
              j      <= oldest;
              issued <= '0;
            end else begin
              bank <= !bank;
              wp   <= (fill == cap_eff) ? '0 : fill;
            end
          end
        end
        default: begin
        end
      endcase
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, fill, res_served, res_status};
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= cap_eff)
    else $error("fill count above capacity");

  a_wp_bound: assert property (@(posedge clk) disable iff (rst)
    wp < cap_eff)
    else $error("write pointer outside capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(out_load && m_tvalid && !m_tready))
    else $error("pending result overwritten");

  a_walk_count: assert property (@(posedge clk) disable iff (rst)
    (state == sqp_pkg::ST_WALK) |-> (n <= fill) && (issued <= fill))
    else $error("promote walk count out of range");

  a_enq_fill: assert property (@(posedge clk) disable iff (rst)
    (accept && in_mode == sqp_pkg::MODE_ENQ && enq_ok && !cfg_we)
      |=> fill == $past(fill) + CW'(1))
    else $error("enqueue did not advance fill count");

endmodule

// ===== design/sqp_store.sv =====
module sqp_store #(
  parameter int AW = 4
) (
  input  logic                 clk,
  input  sqp_pkg::store_ctl_t  ctl,
  output logic [7:0]           rdata
);

  logic [7:0] mem [2**(AW+1)];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[{ctl.wbank, ctl.wptr[AW-1:0]}] <= ctl.wdata;
    end
    rdata <= mem[{ctl.rbank, ctl.rptr[AW-1:0]}];
  end

endmodule
